// File: hdl/trd_pkg.sv
package trd_pkg;

    localparam int unsigned DEFAULT_MAX_PIXEL_BYTES = 4;

    localparam int unsigned BPP_W      = 3;
    localparam int unsigned PIXCNT_W   = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PIXEL_W    = 32;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned PIX_LANES  = PIXEL_W / BYTE_W;

    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT     = 2'd1;

    localparam logic [BPP_W-1:0]    BPP_RESET    = 3'd4;
    localparam logic [PIXCNT_W-1:0] PIXCNT_RESET = 32'd1;

    localparam logic [BYTE_W-1:0] HDR_RUN_MASK   = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_COUNT_MASK = 8'h7F;

    typedef struct packed {
        logic [BPP_W-1:0]    bytes_per_pixel;
        logic [PIXCNT_W-1:0] pixel_count;
    } t_cfg;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_value;
        logic [COUNT_W-1:0] repeat_count;
        logic               image_end;
        logic               overrun;
    } t_result;

endpackage

// File: hdl/tga_rle_pixel_decoder.sv
// Decodes a TGA run-length stream one byte per beat at a sustained rate of one
// byte per cycle unless the output stalls. A byte passes an input register, the
// packet/pixel logic and a result register before its result is presented.
// Header bytes and non-final pixel bytes give no result; each finished
// pixel gives one beat (count 1 for raw packets, packet count for repeat packets),
// and a header asking for more pixels than the image has left gives an overrun
// beat with count 0 that also ends the image. Write bytes_per_pixel (index 0) and
// pixel_count (index 1) only while the block is idle; writing pixel_count starts
// a new image.
module tga_rle_pixel_decoder
    import trd_pkg::*;
#(
    parameter int unsigned MAX_PIXEL_BYTES = DEFAULT_MAX_PIXEL_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_data_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIXEL_W-1:0]    o_pixel_value,
    output logic [COUNT_W-1:0]    o_repeat_count,
    output logic                  o_image_end,
    output logic                  o_overrun,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_out_valid;
    t_result             r_out;

    logic                advance;
    logic                in_take;
    t_cfg                cfg;
    logic                reload;
    logic [PIXCNT_W-1:0] reload_count;
    logic                res_valid;
    t_result             res;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
        end
    end

    trd_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_cfg          (cfg),
        .o_reload       (reload),
        .o_reload_count (reload_count)
    );

    trd_step #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (advance),
        .i_byte         (r_in_byte),
        .i_cfg          (cfg),
        .i_reload       (reload),
        .i_reload_count (reload_count),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_value  = r_out.pixel_value;
    assign o_repeat_count = r_out.repeat_count;
    assign o_image_end    = r_out.image_end;
    assign o_overrun      = r_out.overrun;

    a_overrun_ends_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.overrun |-> r_out.image_end && r_out.repeat_count == '0)
        else $error("overrun beat must end the image with count 0");

    a_pixel_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.overrun |-> r_out.repeat_count != '0)
        else $error("pixel beat with zero repeat count");

    a_no_loss_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_out_stall |=> r_in_valid)
        else $error("pending byte dropped while output stalled");

endmodule

// File: hdl/trd_cfg.sv
module trd_cfg
    import trd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic                  o_reload,
    output logic [PIXCNT_W-1:0]   o_reload_count
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_bpp;
    logic wr_cnt;

    assign wr_bpp = i_cfg_we && (i_cfg_idx == REG_BYTES_PER_PIXEL);
    assign wr_cnt = i_cfg_we && (i_cfg_idx == REG_PIXEL_COUNT);

    always_comb begin
        n_cfg = r_cfg;
        if (wr_bpp) begin
            n_cfg.bytes_per_pixel = i_cfg_data[BPP_W-1:0];
        end
        if (wr_cnt) begin
            n_cfg.pixel_count = i_cfg_data[PIXCNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_pixel <= BPP_RESET;
            r_cfg.pixel_count     <= PIXCNT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg          = r_cfg;
    // new image size drops any partial packet in the decoder
    assign o_reload       = wr_cnt;
    assign o_reload_count = i_cfg_data[PIXCNT_W-1:0];

endmodule

// File: hdl/trd_step.sv
module trd_step
    import trd_pkg::*;
#(
    parameter int unsigned MAX_PIXEL_BYTES = DEFAULT_MAX_PIXEL_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [BYTE_W-1:0]   i_byte,
    input  t_cfg                i_cfg,
    input  logic                i_reload,
    input  logic [PIXCNT_W-1:0] i_reload_count,
    output logic                o_res_valid,
    output t_result             o_res
);

    localparam int unsigned POS_W = $clog2(MAX_PIXEL_BYTES + 1);

    logic                r_in_packet;
    logic                r_is_run;
    logic [COUNT_W-1:0]  r_pkt_left;
    logic [POS_W-1:0]    r_pos;
    logic [PIXEL_W-1:0]  r_gather;
    logic [PIXCNT_W-1:0] r_img_left;

    logic                n_in_packet;
    logic                n_is_run;
    logic [COUNT_W-1:0]  n_pkt_left;
    logic [POS_W-1:0]    n_pos;
    logic [PIXEL_W-1:0]  n_gather;
    logic [PIXCNT_W-1:0] n_img_left;

    logic [POS_W-1:0]    depth;
    logic [COUNT_W-1:0]  hdr_count;
    logic [PIXEL_W-1:0]  gathered;
    logic [POS_W-1:0]    pos_inc;
    logic [COUNT_W-1:0]  cnt;
    logic [COUNT_W-1:0]  pkt_after;
    logic                img_done;

    always_comb begin
        if (i_cfg.bytes_per_pixel == '0) begin
            depth = POS_W'(1);
        end else if (32'(i_cfg.bytes_per_pixel) > MAX_PIXEL_BYTES) begin
            depth = POS_W'(MAX_PIXEL_BYTES);
        end else begin
            depth = POS_W'(i_cfg.bytes_per_pixel);
        end
    end

    assign hdr_count = (i_byte & HDR_COUNT_MASK) + COUNT_W'(1);
    assign pos_inc   = r_pos + POS_W'(1);

    always_comb begin
        for (int k = 0; k < PIX_LANES; k++) begin
            if (32'(r_pos) == k) begin
                gathered[k*BYTE_W +: BYTE_W] = i_byte;
            end else begin
                gathered[k*BYTE_W +: BYTE_W] = r_gather[k*BYTE_W +: BYTE_W];
            end
        end
    end

    assign cnt       = r_is_run ? r_pkt_left : COUNT_W'(1);
    assign pkt_after = (r_is_run || r_pkt_left == '0) ? '0 : r_pkt_left - COUNT_W'(1);
    assign img_done  = r_img_left <= PIXCNT_W'(cnt);

    always_comb begin
        n_in_packet = r_in_packet;
        n_is_run    = r_is_run;
        n_pkt_left  = r_pkt_left;
        n_pos       = r_pos;
        n_gather    = r_gather;
        n_img_left  = r_img_left;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_reload) begin
            n_in_packet = 1'b0;
            n_is_run    = 1'b0;
            n_pkt_left  = '0;
            n_pos       = '0;
            n_gather    = '0;
            n_img_left  = i_reload_count;
        end else if (i_valid && !r_in_packet) begin
            if (PIXCNT_W'(hdr_count) > r_img_left) begin
                o_res_valid        = 1'b1;
                o_res.image_end    = 1'b1;
                o_res.overrun      = 1'b1;
                n_is_run           = 1'b0;
                n_pkt_left         = '0;
                n_pos              = '0;
                n_gather           = '0;
                n_img_left         = i_cfg.pixel_count;
            end else begin
                n_in_packet = 1'b1;
                n_is_run    = (i_byte & HDR_RUN_MASK) != '0;
                n_pkt_left  = hdr_count;
                n_pos       = '0;
                n_gather    = '0;
            end
        end else if (i_valid) begin
            if (pos_inc < depth) begin
                n_pos    = pos_inc;
                n_gather = gathered;
            end else begin
                o_res_valid        = 1'b1;
                o_res.pixel_value  = gathered;
                o_res.repeat_count = cnt;
                o_res.image_end    = img_done;
                n_pos              = '0;
                n_gather           = '0;
                n_pkt_left         = pkt_after;
                if (pkt_after == '0 || img_done) begin
                    n_in_packet = 1'b0;
                    n_is_run    = 1'b0;
                    n_pkt_left  = '0;
                end
                if (img_done) begin
                    n_img_left = i_cfg.pixel_count;
                end else begin
                    n_img_left = r_img_left - PIXCNT_W'(cnt);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_is_run    <= 1'b0;
            r_pkt_left  <= '0;
            r_pos       <= '0;
            r_gather    <= '0;
            r_img_left  <= PIXCNT_RESET;
        end else begin
            r_in_packet <= n_in_packet;
            r_is_run    <= n_is_run;
            r_pkt_left  <= n_pkt_left;
            r_pos       <= n_pos;
            r_gather    <= n_gather;
            r_img_left  <= n_img_left;
        end
    end

endmodule
